FILE: design/wkc_pkg.sv
package wkc_pkg;

  // count storage
  localparam int COUNT_WIDTH   = 16;
  localparam int ALPHABET_SIZE = 4;
  localparam int CODE_W        = $clog2(ALPHABET_SIZE);
  localparam int DI_ENTRIES    = ALPHABET_SIZE ** 2;
  localparam int TRI_ROWS      = ALPHABET_SIZE ** 2;
  localparam int TETRA_ROWS    = ALPHABET_SIZE ** 3;
  localparam int DI_W          = $clog2(DI_ENTRIES);
  localparam int TRI_ROW_W     = $clog2(TRI_ROWS);
  localparam int TETRA_ROW_W   = $clog2(TETRA_ROWS);
  localparam int TRI_AW        = TRI_ROW_W + 1;
  localparam int TETRA_AW      = TETRA_ROW_W + 1;

  // field widths
  localparam int OP_W    = 2;
  localparam int SYM_W   = 8;
  localparam int IDX_W   = 9;
  localparam int WLEN_W  = 16;
  localparam int FILL_W  = WLEN_W + 1;
  localparam int COORD_W = 32;
  localparam int VALUE_W = 16;

  // flat read index layout
  localparam logic [IDX_W-1:0] DI_BASE    = IDX_W'(4);
  localparam logic [IDX_W-1:0] TRI_BASE   = IDX_W'(20);
  localparam logic [IDX_W-1:0] TETRA_BASE = IDX_W'(84);
  localparam logic [IDX_W-1:0] TABLE_SIZE = IDX_W'(340);

  localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(1000);

  // result queue
  localparam int OUTQ_DEPTH = 3;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  // ascii symbols
  localparam logic [SYM_W-1:0] SYM_A_UP = 8'h41;
  localparam logic [SYM_W-1:0] SYM_A_LO = 8'h61;
  localparam logic [SYM_W-1:0] SYM_C_UP = 8'h43;
  localparam logic [SYM_W-1:0] SYM_C_LO = 8'h63;
  localparam logic [SYM_W-1:0] SYM_G_UP = 8'h47;
  localparam logic [SYM_W-1:0] SYM_G_LO = 8'h67;
  localparam logic [SYM_W-1:0] SYM_T_UP = 8'h54;
  localparam logic [SYM_W-1:0] SYM_T_LO = 8'h74;
  localparam logic [SYM_W-1:0] SYM_N_UP = 8'h4E;
  localparam logic [SYM_W-1:0] SYM_N_LO = 8'h6E;

  localparam logic [CODE_W-1:0] CODE_A = CODE_W'(0);
  localparam logic [CODE_W-1:0] CODE_C = CODE_W'(1);
  localparam logic [CODE_W-1:0] CODE_G = CODE_W'(2);
  localparam logic [CODE_W-1:0] CODE_T = CODE_W'(3);

  localparam logic KIND_WINDOW = 1'b0;
  localparam logic KIND_COUNT  = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_BASE = 2'd0,
    OP_EOR  = 2'd1,
    OP_READ = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    SEL_NONE,
    SEL_MONO,
    SEL_DI,
    SEL_TRI,
    SEL_TETRA
  } rd_sel_e;

  typedef logic [ALPHABET_SIZE-1:0][COUNT_WIDTH-1:0] row_t;

  typedef struct packed {
    logic en;
    logic bank;
  } clear_t;

  typedef struct packed {
    logic                    vld;
    logic                    upd;
    logic                    rd;
    logic                    res;
    logic                    bank;
    logic                    di_en;
    logic                    tri_en;
    logic                    tetra_en;
    rd_sel_e                 sel;
    logic [CODE_W-1:0]       lane;
    logic [DI_W-1:0]         di_idx;
    logic [TRI_ROW_W-1:0]    tri_row;
    logic [TETRA_ROW_W-1:0]  tetra_row;
    logic                    kind;
    logic [COORD_W-1:0]      win_begin;
    logic [COORD_W-1:0]      win_end;
  } stage_t;

  typedef struct packed {
    logic                kind;
    logic [COORD_W-1:0]  win_begin;
    logic [COORD_W-1:0]  win_end;
    logic [VALUE_W-1:0]  value;
  } res_t;

  typedef struct packed {
    logic vld;
    res_t data;
  } push_t;

  // base byte to 2-bit code, unknown bytes map to A
  function automatic logic [CODE_W-1:0] sym_code(input logic [SYM_W-1:0] sym);
    logic [CODE_W-1:0] c;
    c = CODE_A;
    if (sym == SYM_A_UP || sym == SYM_A_LO) c = CODE_A;
    else if (sym == SYM_C_UP || sym == SYM_C_LO) c = CODE_C;
    else if (sym == SYM_G_UP || sym == SYM_G_LO) c = CODE_G;
    else if (sym == SYM_T_UP || sym == SYM_T_LO) c = CODE_T;
    return c;
  endfunction

  // saturating increment of one count
  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    return (c == {COUNT_WIDTH{1'b1}}) ? c : c + COUNT_WIDTH'(1);
  endfunction

  // count to output field width
  function automatic logic [VALUE_W-1:0] to_out(input logic [COUNT_WIDTH-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return w[VALUE_W-1:0];
  endfunction

endpackage

FILE: design/wkc_ram.sv
module wkc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/wkc_ctrl.sv
module wkc_ctrl import wkc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [WLEN_W-1:0]  cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               room_i,
  input  logic [OP_W-1:0]    op_i,
  input  logic [SYM_W-1:0]   symbol_i,
  input  logic [IDX_W-1:0]   count_index_i,
  output logic               in_stall_o,
  output stage_t             req_o,
  output clear_t             clr_o
);

  logic                    active_q, active_d;
  logic [3*CODE_W-1:0]     codes_q, codes_d;
  logic [2:0]              rv_q, rv_d;
  logic [WLEN_W-1:0]       fill_q, fill_d;
  logic [COORD_W-1:0]      pos_q, pos_d;
  logic [WLEN_W-1:0]       wlen_q;

  logic                    accept;
  logic                    is_base, is_eor, is_read;
  logic                    gap;
  logic [CODE_W-1:0]       code, p0, p1, p2;
  logic [FILL_W-1:0]       limit, fill_inc, fill_cur;
  logic [COORD_W:0]        end_sum;
  logic [COORD_W-1:0]      end_sat;
  logic                    finish;
  logic [IDX_W-1:0]        off_di, off_tri, off_tetra;

  // request handshake
  assign in_stall_o = ~room_i;
  assign accept     = in_valid_i & room_i;

  assign is_base = (op_i == OP_BASE);
  assign is_eor  = (op_i == OP_EOR);
  assign is_read = (op_i == OP_READ);

  // base decode and recent context
  assign gap  = (symbol_i == SYM_N_UP) || (symbol_i == SYM_N_LO);
  assign code = sym_code(symbol_i);
  assign p0   = codes_q[CODE_W-1:0];
  assign p1   = codes_q[2*CODE_W-1:CODE_W];
  assign p2   = codes_q[3*CODE_W-1:2*CODE_W];

  // window fill and end coordinate
  assign limit    = (wlen_q == '0) ? (FILL_W'(1) << WLEN_W) : {1'b0, wlen_q};
  assign fill_inc = {1'b0, fill_q} + FILL_W'(1);
  assign fill_cur = is_base ? fill_inc : {1'b0, fill_q};
  assign end_sum  = {1'b0, pos_q} + (COORD_W + 1)'(fill_cur);
  assign end_sat  = end_sum[COORD_W] ? {COORD_W{1'b1}} : end_sum[COORD_W-1:0];
  assign finish   = (is_base && (fill_inc >= limit)) || (is_eor && (fill_q != '0));

  // read index offsets
  assign off_di    = count_index_i - DI_BASE;
  assign off_tri   = count_index_i - TRI_BASE;
  assign off_tetra = count_index_i - TETRA_BASE;

  // request to the count tables
  always_comb begin
    req_o           = '0;
    req_o.upd       = is_base && !gap;
    req_o.res       = finish || is_read;
    req_o.rd        = is_read;
    req_o.vld       = accept && (req_o.upd || req_o.res);
    req_o.bank      = is_read ? ~active_q : active_q;
    req_o.kind      = is_read ? KIND_COUNT : KIND_WINDOW;
    req_o.win_begin = is_read ? '0 : pos_q;
    req_o.win_end   = is_read ? '0 : end_sat;
    req_o.sel       = SEL_NONE;
    if (is_read) begin
      priority if (count_index_i < DI_BASE) begin
        req_o.sel  = SEL_MONO;
        req_o.lane = count_index_i[CODE_W-1:0];
      end else if (count_index_i < TRI_BASE) begin
        req_o.sel    = SEL_DI;
        req_o.di_idx = off_di[DI_W-1:0];
      end else if (count_index_i < TETRA_BASE) begin
        req_o.sel     = SEL_TRI;
        req_o.tri_row = off_tri[CODE_W +: TRI_ROW_W];
        req_o.lane    = off_tri[CODE_W-1:0];
      end else if (count_index_i < TABLE_SIZE) begin
        req_o.sel       = SEL_TETRA;
        req_o.tetra_row = off_tetra[CODE_W +: TETRA_ROW_W];
        req_o.lane      = off_tetra[CODE_W-1:0];
      end else begin
        req_o.sel = SEL_NONE;
      end
    end else begin
      req_o.lane      = code;
      req_o.di_idx    = {p0, code};
      req_o.tri_row   = {p1, p0};
      req_o.tetra_row = {p2, p1, p0};
      req_o.di_en     = rv_q[0];
      req_o.tri_en    = (rv_q[1:0] == 2'b11);
      req_o.tetra_en  = (rv_q == 3'b111);
    end
  end

  // a finished window clears the bank that takes over counting
  assign clr_o.en   = accept && finish;
  assign clr_o.bank = ~active_q;

  // window and record state
  always_comb begin
    active_d = active_q;
    codes_d  = codes_q;
    rv_d     = rv_q;
    fill_d   = fill_q;
    pos_d    = pos_q;
    if (accept) begin
      unique case (op_i)
        OP_BASE: begin
          codes_d = {codes_q[2*CODE_W-1:0], code};
          if (finish) begin
            active_d = ~active_q;
            pos_d    = end_sat;
            fill_d   = '0;
            rv_d     = '0;
          end else begin
            fill_d = fill_inc[WLEN_W-1:0];
            rv_d   = {rv_q[1:0], ~gap};
          end
        end
        OP_EOR: begin
          if (finish) begin
            active_d = ~active_q;
          end
          pos_d   = '0;
          fill_d  = '0;
          codes_d = '0;
          rv_d    = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      codes_q  <= '0;
      rv_q     <= '0;
      fill_q   <= '0;
      pos_q    <= '0;
    end else begin
      active_q <= active_d;
      codes_q  <= codes_d;
      rv_q     <= rv_d;
      fill_q   <= fill_d;
      pos_q    <= pos_d;
    end
  end

  // window length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= WLEN_RESET;
    end else if (cfg_we_i) begin
      wlen_q <= cfg_wdata_i;
    end
  end

`ifndef SYNTHESIS
  a_bank_swap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_o.en |=> (active_q != $past(active_q)))
    else $error("bank did not swap on window finish");

  a_eor_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_eor) |=> (fill_q == '0 && rv_q == '0 && pos_q == '0))
    else $error("record state not cleared at end of record");
`endif

endmodule

FILE: design/wkc_table.sv
module wkc_table import wkc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  stage_t req_i,
  input  clear_t clr_i,
  output push_t  push_o
);

  stage_t s1_q;

  logic [1:0][TRI_ROWS-1:0]   tri_vld_q, tri_vld_d;
  logic [1:0][TETRA_ROWS-1:0] tetra_vld_q, tetra_vld_d;

  logic [1:0][ALPHABET_SIZE-1:0][COUNT_WIDTH-1:0] mono_q, mono_d;
  logic [1:0][DI_ENTRIES-1:0][COUNT_WIDTH-1:0]    di_q, di_d;

  row_t                tri_rdata, tetra_rdata;
  row_t                tri_cur, tetra_cur, tri_new, tetra_new;
  logic [TRI_AW-1:0]   tri_addr;
  logic [TETRA_AW-1:0] tetra_addr;
  logic                tri_we, tetra_we, tri_hit, tetra_hit, mono_we, di_we;

  logic                fwd_tri_v_q, fwd_tetra_v_q;
  logic [TRI_AW-1:0]   fwd_tri_addr_q;
  logic [TETRA_AW-1:0] fwd_tetra_addr_q;
  row_t                fwd_tri_data_q, fwd_tetra_data_q;

  logic [COUNT_WIDTH-1:0] rd_cnt;

  // stage register: one request in flight behind the memory read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else begin
      s1_q <= req_i;
    end
  end

  assign tri_addr   = {s1_q.bank, s1_q.tri_row};
  assign tetra_addr = {s1_q.bank, s1_q.tetra_row};
  assign tri_we     = s1_q.vld && s1_q.upd && s1_q.tri_en;
  assign tetra_we   = s1_q.vld && s1_q.upd && s1_q.tetra_en;
  assign mono_we    = s1_q.vld && s1_q.upd;
  assign di_we      = s1_q.vld && s1_q.upd && s1_q.di_en;

  // tri and tetra count rows, read at request, written in the following cycle
  wkc_ram #(
    .WIDTH ($bits(row_t)),
    .DEPTH (2 * TRI_ROWS)
  ) u_tri_ram (
    .clk_i   (clk_i),
    .we_i    (tri_we),
    .waddr_i (tri_addr),
    .wdata_i (tri_new),
    .re_i    (req_i.vld),
    .raddr_i ({req_i.bank, req_i.tri_row}),
    .rdata_o (tri_rdata)
  );

  wkc_ram #(
    .WIDTH ($bits(row_t)),
    .DEPTH (2 * TETRA_ROWS)
  ) u_tetra_ram (
    .clk_i   (clk_i),
    .we_i    (tetra_we),
    .waddr_i (tetra_addr),
    .wdata_i (tetra_new),
    .re_i    (req_i.vld),
    .raddr_i ({req_i.bank, req_i.tetra_row}),
    .rdata_o (tetra_rdata)
  );

  // row value: last write forwarded, rows not written since clear read as zero
  assign tri_hit   = fwd_tri_v_q && (fwd_tri_addr_q == tri_addr);
  assign tetra_hit = fwd_tetra_v_q && (fwd_tetra_addr_q == tetra_addr);

  always_comb begin
    if (tri_hit) begin
      tri_cur = fwd_tri_data_q;
    end else if (tri_vld_q[s1_q.bank][s1_q.tri_row]) begin
      tri_cur = tri_rdata;
    end else begin
      tri_cur = '0;
    end
    if (tetra_hit) begin
      tetra_cur = fwd_tetra_data_q;
    end else if (tetra_vld_q[s1_q.bank][s1_q.tetra_row]) begin
      tetra_cur = tetra_rdata;
    end else begin
      tetra_cur = '0;
    end
  end

  // modify one lane of each row
  always_comb begin
    tri_new              = tri_cur;
    tri_new[s1_q.lane]   = sat_inc(tri_cur[s1_q.lane]);
    tetra_new            = tetra_cur;
    tetra_new[s1_q.lane] = sat_inc(tetra_cur[s1_q.lane]);
  end

  // forwarding of the row written this cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_tri_v_q   <= 1'b0;
      fwd_tetra_v_q <= 1'b0;
    end else begin
      fwd_tri_v_q   <= tri_we;
      fwd_tetra_v_q <= tetra_we;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_tri_addr_q   <= tri_addr;
    fwd_tri_data_q   <= tri_new;
    fwd_tetra_addr_q <= tetra_addr;
    fwd_tetra_data_q <= tetra_new;
  end

  // row valid bits, bank clear wins over a late write into that bank
  always_comb begin
    tri_vld_d   = tri_vld_q;
    tetra_vld_d = tetra_vld_q;
    if (tri_we) begin
      tri_vld_d[s1_q.bank][s1_q.tri_row] = 1'b1;
    end
    if (tetra_we) begin
      tetra_vld_d[s1_q.bank][s1_q.tetra_row] = 1'b1;
    end
    if (clr_i.en) begin
      tri_vld_d[clr_i.bank]   = '0;
      tetra_vld_d[clr_i.bank] = '0;
    end
  end

  // mono and di counters, each with its own incrementer
  always_comb begin
    for (int b = 0; b < 2; b++) begin
      for (int e = 0; e < ALPHABET_SIZE; e++) begin
        mono_d[b][e] = mono_q[b][e];
        if (clr_i.en && clr_i.bank == 1'(b)) begin
          mono_d[b][e] = '0;
        end else if (mono_we && s1_q.bank == 1'(b) && s1_q.lane == CODE_W'(e)) begin
          mono_d[b][e] = sat_inc(mono_q[b][e]);
        end
      end
      for (int e = 0; e < DI_ENTRIES; e++) begin
        di_d[b][e] = di_q[b][e];
        if (clr_i.en && clr_i.bank == 1'(b)) begin
          di_d[b][e] = '0;
        end else if (di_we && s1_q.bank == 1'(b) && s1_q.di_idx == DI_W'(e)) begin
          di_d[b][e] = sat_inc(di_q[b][e]);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tri_vld_q   <= '0;
      tetra_vld_q <= '0;
      mono_q      <= '0;
      di_q        <= '0;
    end else begin
      tri_vld_q   <= tri_vld_d;
      tetra_vld_q <= tetra_vld_d;
      mono_q      <= mono_d;
      di_q        <= di_d;
    end
  end

  // frozen count read
  always_comb begin
    unique case (s1_q.sel)
      SEL_MONO:  rd_cnt = mono_q[s1_q.bank][s1_q.lane];
      SEL_DI:    rd_cnt = di_q[s1_q.bank][s1_q.di_idx];
      SEL_TRI:   rd_cnt = tri_cur[s1_q.lane];
      SEL_TETRA: rd_cnt = tetra_cur[s1_q.lane];
      SEL_NONE:  rd_cnt = '0;
      default:   rd_cnt = '0;
    endcase
  end

  // result toward the output queue
  assign push_o.vld            = s1_q.vld && s1_q.res;
  assign push_o.data.kind      = s1_q.kind;
  assign push_o.data.win_begin = s1_q.win_begin;
  assign push_o.data.win_end   = s1_q.win_end;
  assign push_o.data.value     = s1_q.rd ? to_out(rd_cnt) : '0;

`ifndef SYNTHESIS
  a_clear_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_i.en |=> (tri_vld_q[$past(clr_i.bank)] == '0 &&
                  tetra_vld_q[$past(clr_i.bank)] == '0))
    else $error("row valid bits survived a bank clear");

  a_kmer_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tetra_we |-> (tri_we && di_we))
    else $error("tetra update without tri and di updates");
`endif

endmodule

FILE: design/wkc_outq.sv
module wkc_outq import wkc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  push_t               push_i,
  input  logic                out_stall_i,
  output logic                room_o,
  output logic                out_valid_o,
  output logic                kind_o,
  output logic [COORD_W-1:0]  window_begin_o,
  output logic [COORD_W-1:0]  window_end_o,
  output logic [VALUE_W-1:0]  count_value_o
);

  res_t                  mem_q [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [OUTQ_CNT_W-1:0] occ_q, occ_d;
  logic                  pop;
  res_t                  head;

  // head of queue drives the result port
  assign head           = mem_q[rd_ptr_q];
  assign out_valid_o    = (occ_q != '0);
  assign kind_o         = head.kind;
  assign window_begin_o = head.win_begin;
  assign window_end_o   = head.win_end;
  assign count_value_o  = head.value;
  assign pop            = out_valid_o && !out_stall_i;

  // credit for a new request: stored results plus one still in the pipe
  assign room_o = ((OUTQ_CNT_W + 1)'(occ_q) + (OUTQ_CNT_W + 1)'(push_i.vld))
                  < (OUTQ_CNT_W + 1)'(OUTQ_DEPTH);

  always_comb begin
    occ_d = occ_q;
    if (push_i.vld && !pop) begin
      occ_d = occ_q + OUTQ_CNT_W'(1);
    end else if (!push_i.vld && pop) begin
      occ_d = occ_q - OUTQ_CNT_W'(1);
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      occ_q    <= '0;
    end else begin
      occ_q <= occ_d;
      if (push_i.vld) begin
        wr_ptr_q <= (wr_ptr_q == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0
                    : wr_ptr_q + OUTQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0
                    : rd_ptr_q + OUTQ_PTR_W'(1);
      end
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push_i.vld) begin
      mem_q[wr_ptr_q] <= push_i.data;
    end
  end

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.vld |-> (occ_q != OUTQ_CNT_W'(OUTQ_DEPTH) || pop))
    else $error("result pushed into a full queue");

  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OUTQ_CNT_W'(OUTQ_DEPTH))
    else $error("queue occupancy out of range");
`endif

endmodule

FILE: design/windowed_kmer_counter.sv
// Windowed k-mer counter for k = 1 to 4.
// Request channel (in_valid_i / in_stall_o, taken when valid and not stalled):
//   op_i = base byte, end of record, or read of a frozen count at count_index_i.
// Result channel (out_valid_o / out_stall_i): a window result (kind 0) with
//   begin and end record coordinates when a window fills or a record ends with
//   a partial window, or a count read result (kind 1) for every read request.
// window_length is written through cfg_we_i / cfg_wdata_i, by the user only while
//   the block is idle (the block itself does not enforce it); zero means 65536 positions.
// Throughput: one request per cycle, sustained, as long as results drain. The
//   tri and tetra count rows live in two dual-port RAMs that are read when a
//   request is taken and written back in the cycle after, with the last written
//   row forwarded; mono and di counts are flip-flops.
// Result path: a result passes through the stage register and is then written
//   into the result queue, whose head drives the output port.
// Stall: results wait in a three-entry queue; in_stall_o rises when the queue
//   together with the result still in the pipe could fill it.
// Reset: all counts read as zero, both banks empty, record coordinate zero,
//   window length 1000, queue empty. No clearing pass: a bank clear resets the
//   tri and tetra per-row valid bits and zeroes the mono and di flip-flops.
module windowed_kmer_counter import wkc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [WLEN_W-1:0]   cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [OP_W-1:0]     op_i,
  input  logic [SYM_W-1:0]    symbol_i,
  input  logic [IDX_W-1:0]    count_index_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                kind_o,
  output logic [COORD_W-1:0]  window_begin_o,
  output logic [COORD_W-1:0]  window_end_o,
  output logic [VALUE_W-1:0]  count_value_o
);

  stage_t req;
  clear_t clr;
  push_t  push;
  logic   room;

  // window state and request decode
  wkc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .room_i        (room),
    .op_i          (op_i),
    .symbol_i      (symbol_i),
    .count_index_i (count_index_i),
    .in_stall_o    (in_stall_o),
    .req_o         (req),
    .clr_o         (clr)
  );

  // count banks
  wkc_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .clr_i  (clr),
    .push_o (push)
  );

  // result queue
  wkc_outq u_outq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .out_stall_i    (out_stall_i),
    .room_o         (room),
    .out_valid_o    (out_valid_o),
    .kind_o         (kind_o),
    .window_begin_o (window_begin_o),
    .window_end_o   (window_end_o),
    .count_value_o  (count_value_o)
  );

endmodule

FILE: dv/wkc_checker.sv
module wkc_checker import wkc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [WLEN_W-1:0]  cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [OP_W-1:0]    op_i,
  input  logic [SYM_W-1:0]   symbol_i,
  input  logic [IDX_W-1:0]   count_index_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               kind_i,
  input  logic [COORD_W-1:0] window_begin_i,
  input  logic [COORD_W-1:0] window_end_i,
  input  logic [VALUE_W-1:0] count_value_i,
  output int                 fail_count_o,
  output int                 results_due_o,
  output int                 windows_seen_o,
  output int                 reads_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_N = int'(TABLE_SIZE);

  // predicted block state: two count banks, one counting, one frozen
  logic [COUNT_WIDTH-1:0] kmer_counts [2][TABLE_N];
  logic                   live_bank;
  logic [3*CODE_W-1:0]    recent_bases;
  logic [2:0]             recent_ok;
  logic [FILL_W-1:0]      fill;
  logic [COORD_W-1:0]     window_start;
  logic [WLEN_W-1:0]      window_len;

  // window and count results still to come, oldest first
  res_t results_due[$];
  res_t oldest;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fail_count_o++;
  endtask

  function automatic logic [CODE_W-1:0] base_code(input logic [SYM_W-1:0] sym);
    case (sym)
      SYM_C_UP, SYM_C_LO: return CODE_C;
      SYM_G_UP, SYM_G_LO: return CODE_G;
      SYM_T_UP, SYM_T_LO: return CODE_T;
      default:            return CODE_A;
    endcase
  endfunction

  // saturating bump in the counting bank
  task automatic bump_kmer(input int idx);
    if (kmer_counts[live_bank][idx] != {COUNT_WIDTH{1'b1}}) begin
      kmer_counts[live_bank][idx] += 1'b1;
    end
  endtask

  // report the window, freeze its bank, clear the other one
  task automatic freeze_window();
    logic [COORD_W:0] stop;
    res_t r;
    stop = window_start;
    stop = stop + fill;
    if (stop[COORD_W]) begin
      stop = {1'b0, {COORD_W{1'b1}}};
    end
    r.kind      = KIND_WINDOW;
    r.win_begin = window_start;
    r.win_end   = stop[COORD_W-1:0];
    r.value     = '0;
    results_due.push_back(r);
    window_start = stop[COORD_W-1:0];
    fill         = '0;
    recent_ok    = '0;
    live_bank    = !live_bank;
    for (int i = 0; i < TABLE_N; i++) begin
      kmer_counts[live_bank][i] = '0;
    end
  endtask

  // advance the predicted state by one accepted request
  task automatic count_request(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                               input logic [IDX_W-1:0] idx);
    logic              gap;
    logic [CODE_W-1:0] c, p0, p1, p2;
    logic [FILL_W-1:0] limit;
    res_t              r;
    case (op)
      OP_BASE: begin
        gap = (sym == SYM_N_UP) || (sym == SYM_N_LO);
        c   = base_code(sym);
        p0  = recent_bases[CODE_W-1:0];
        p1  = recent_bases[2*CODE_W-1:CODE_W];
        p2  = recent_bases[3*CODE_W-1:2*CODE_W];
        if (!gap) begin
          bump_kmer(int'(c));
          if (recent_ok[0]) begin
            bump_kmer(int'(DI_BASE) + int'(p0) * ALPHABET_SIZE + int'(c));
          end
          if (recent_ok[1:0] == 2'b11) begin
            bump_kmer(int'(TRI_BASE) + (int'(p1) * ALPHABET_SIZE + int'(p0)) * ALPHABET_SIZE
                      + int'(c));
          end
          if (recent_ok == 3'b111) begin
            bump_kmer(int'(TETRA_BASE)
                      + ((int'(p2) * ALPHABET_SIZE + int'(p1)) * ALPHABET_SIZE + int'(p0))
                        * ALPHABET_SIZE + int'(c));
          end
        end
        recent_bases = {recent_bases[2*CODE_W-1:0], c};
        recent_ok    = {recent_ok[1:0], !gap};
        fill         = fill + 1'b1;
        // zero length means the full 65536 positions
        limit = (window_len == '0) ? {1'b1, {WLEN_W{1'b0}}} : {1'b0, window_len};
        if (fill >= limit) begin
          freeze_window();
        end
      end
      OP_EOR: begin
        if (fill != '0) begin
          freeze_window();
        end
        window_start = '0;
        fill         = '0;
        recent_bases = '0;
        recent_ok    = '0;
      end
      OP_READ: begin
        r.kind      = KIND_COUNT;
        r.win_begin = '0;
        r.win_end   = '0;
        r.value     = '0;
        if (idx < TABLE_SIZE) begin
          r.value = kmer_counts[!live_bank][idx][VALUE_W-1:0];
        end
        results_due.push_back(r);
      end
      default: begin
      end
    endcase
  endtask

  // watch both channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < 2; b++) begin
        for (int i = 0; i < TABLE_N; i++) begin
          kmer_counts[b][i] = '0;
        end
      end
      live_bank      = 1'b0;
      recent_bases   = '0;
      recent_ok      = '0;
      fill           = '0;
      window_start   = '0;
      window_len     = WLEN_RESET;
      results_due.delete();
      fail_count_o   = 0;
      results_due_o  = 0;
      windows_seen_o = 0;
      reads_seen_o   = 0;
    end else begin
      // compare each taken result with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d begin %0d end %0d value %0d",
                                    kind_i, window_begin_i, window_end_i, count_value_i));
        end else begin
          oldest = results_due.pop_front();
          if (oldest.kind == KIND_WINDOW) windows_seen_o++;
          else reads_seen_o++;
          if (kind_i !== oldest.kind) begin
            report_mismatch($sformatf("kind %0d, predicted %0d", kind_i, oldest.kind));
          end
          if (window_begin_i !== oldest.win_begin) begin
            report_mismatch($sformatf("window_begin %0d, predicted %0d",
                                      window_begin_i, oldest.win_begin));
          end
          if (window_end_i !== oldest.win_end) begin
            report_mismatch($sformatf("window_end %0d, predicted %0d",
                                      window_end_i, oldest.win_end));
          end
          if (count_value_i !== oldest.value) begin
            report_mismatch($sformatf("count_value %0d, predicted %0d",
                                      count_value_i, oldest.value));
          end
        end
      end
      if (cfg_we_i) begin
        window_len = cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_i) begin
        count_request(op_i, symbol_i, count_index_i);
      end
      results_due_o = results_due.size();
    end
  end

endmodule

FILE: dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wkc_pkg::*;

  // op value with no meaning, must be ignored
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_ITEMS   = 250;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [WLEN_W-1:0]  cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [OP_W-1:0]    op_i = OP_BASE;
  logic [SYM_W-1:0]   symbol_i = '0;
  logic [IDX_W-1:0]   count_index_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               kind_o;
  logic [COORD_W-1:0] window_begin_o;
  logic [COORD_W-1:0] window_end_o;
  logic [VALUE_W-1:0] count_value_o;

  int fail_count;
  int results_due;
  int windows_seen;
  int reads_seen;
  int idle_pct = 0;
  int sent_count = 0;
  int settings_count = 0;

  logic [SYM_W-1:0] opening_bases [12] = '{SYM_A_UP, SYM_C_UP, SYM_G_UP, SYM_T_UP, SYM_N_UP,
                                           SYM_A_LO, SYM_C_LO, SYM_G_LO, SYM_T_LO, SYM_N_LO,
                                           8'hFF, 8'h00};
  logic [IDX_W-1:0] edge_indexes [10] = '{9'd0, 9'd3, DI_BASE, 9'd19, TRI_BASE, 9'd83,
                                          TETRA_BASE, 9'd339, TABLE_SIZE, 9'd511};
  logic [WLEN_W-1:0] window_lengths [7] = '{16'd1, 16'd2, 16'd3, 16'd4, 16'd7, 16'd16,
                                            16'hFFFF};

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  windowed_kmer_counter dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .symbol_i       (symbol_i),
    .count_index_i  (count_index_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .window_begin_o (window_begin_o),
    .window_end_o   (window_end_o),
    .count_value_o  (count_value_o)
  );

  wkc_checker checker_u (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .op_i           (op_i),
    .symbol_i       (symbol_i),
    .count_index_i  (count_index_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_i         (kind_o),
    .window_begin_i (window_begin_o),
    .window_end_i   (window_end_o),
    .count_value_i  (count_value_o),
    .fail_count_o   (fail_count),
    .results_due_o  (results_due),
    .windows_seen_o (windows_seen),
    .reads_seen_o   (reads_seen)
  );

  // random back pressure on the result side
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < idle_pct);
  end

  // one request, with random idle cycles ahead of it
  task automatic send_request(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                              input logic [IDX_W-1:0] idx);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= op;
    symbol_i      <= sym;
    count_index_i <= idx;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    sent_count++;
  endtask

  // hold off requests until every predicted result has been taken
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (results_due != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_window_length(input logic [WLEN_W-1:0] len);
    wait_results_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    settings_count++;
  endtask

  // mostly bases in records, some reads, a few junk ops
  task automatic random_item();
    int               pick;
    logic [SYM_W-1:0] sym;
    logic [IDX_W-1:0] idx;
    pick = $urandom_range(99);
    sym  = SYM_W'($urandom_range(255));
    idx  = IDX_W'($urandom_range(511));
    if (pick < 70) begin
      case ($urandom_range(9))
        0: sym = $urandom_range(1) ? SYM_N_UP : SYM_N_LO;
        1: begin
        end
        default: begin
          case ($urandom_range(7))
            0: sym = SYM_A_UP;
            1: sym = SYM_C_UP;
            2: sym = SYM_G_UP;
            3: sym = SYM_T_UP;
            4: sym = SYM_A_LO;
            5: sym = SYM_C_LO;
            6: sym = SYM_G_LO;
            default: sym = SYM_T_LO;
          endcase
        end
      endcase
      send_request(OP_BASE, sym, idx);
    end else if (pick < 80) begin
      send_request(OP_EOR, sym, idx);
    end else if (pick < 97) begin
      if ($urandom_range(9) != 0) idx = IDX_W'($urandom_range(int'(TABLE_SIZE) - 1));
      send_request(OP_READ, sym, idx);
    end else begin
      send_request(OP_SPARE, sym, idx);
    end
  endtask

  // run limit
  initial begin
    #20ms;
    $display("timeout with %0d results still outstanding", results_due);
    $display("** windowed_kmer_counter: FAILED **");
    $finish;
  end

  // stimulus and verdict
  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    idle_pct = 38;

    // opening checks at the reset window length
    send_request(OP_READ, 8'h00, 9'd0);
    foreach (opening_bases[i]) begin
      send_request(OP_BASE, opening_bases[i], IDX_W'($urandom_range(511)));
    end
    send_request(OP_EOR, 8'h00, 9'd0);
    send_request(OP_EOR, 8'hFF, 9'h1FF);
    send_request(OP_SPARE, 8'hFF, 9'h1FF);
    foreach (edge_indexes[i]) begin
      send_request(OP_READ, SYM_W'($urandom_range(255)), edge_indexes[i]);
    end

    // random phases over a range of window lengths
    for (int p = 0; p < 8; p++) begin
      if (p < 7) write_window_length(window_lengths[p]);
      else write_window_length(WLEN_W'($urandom_range(65535)));
      idle_pct = (p == 5) ? 0 : 38;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == PHASE_ITEMS / 2) wait_results_drained();
        random_item();
      end
    end

    // drain, bounded
    in_valid_i <= 1'b0;
    for (int n = 0; n < 20000 && results_due != 0; n++) @(negedge clk_i);
    repeat (SETTLE_CYCLES * 2) @(negedge clk_i);

    $display("covered %0d requests across %0d window length settings",
             sent_count, settings_count);
    $display("checked %0d window results and %0d count reads", windows_seen, reads_seen);
    if (results_due != 0) $display("%0d predicted results never arrived", results_due);
    if (fail_count == 0 && results_due == 0) begin
      $display("** windowed_kmer_counter: PASSED **");
    end else begin
      $display("** windowed_kmer_counter: FAILED **");
    end
    $finish;
  end

endmodule

FILE: windowed_kmer_counter.f
design/wkc_pkg.sv
design/wkc_ram.sv
design/wkc_ctrl.sv
design/wkc_table.sv
design/wkc_outq.sv
design/windowed_kmer_counter.sv
dv/wkc_checker.sv
dv/tb.sv
